// ----- rtl/dqsr_pkg.sv -----
// Package for the spoofed DNS query responder: sizes, constants, the command
// passed from the front part to the back part, state types and byte-table functions.
// Depends on nothing.
`default_nettype none

package dqsr_pkg;

    localparam int MAX_PACKET = 512;
    localparam int POS_W      = $clog2(MAX_PACKET);
    localparam int HDR_LEN    = 12;
    localparam int ANS_LEN    = 16;
    localparam int IDX_W      = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int ADDR_W     = 3;
    localparam logic [31:0] REPLY_ADDRESS_RESET = 32'hC0A8_0401;
    localparam logic [31:0] ANSWER_TTL_RESET    = 32'd60;

    localparam logic REG_REPLY_ADDRESS = 1'b0;
    localparam logic REG_ANSWER_TTL    = 1'b1;

    localparam logic [2:0] PAD_NAME     = 3'd5;
    localparam logic [2:0] PAD_TYPECLS  = 3'd4;
    localparam logic [1:0] TAIL_LAST    = 2'd3;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'b0001,
        PH_NAME      = 4'b0010,
        PH_TYPECLASS = 4'b0100,
        PH_DROP      = 4'b1000
    } t_phase;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_LEAD = 4'b0010,
        BK_PAD  = 4'b0100,
        BK_ANS  = 4'b1000
    } t_back_state;

    typedef struct packed {
        logic        lead_hdr;
        logic [31:0] data;
        logic        fin;
        logic [2:0]  pad;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                            input logic [31:0] data);
        logic [7:0] b;
        case (idx)
            4'd0:    b = data[31:24];
            4'd1:    b = data[23:16];
            4'd2:    b = 8'h81;
            4'd3:    b = 8'h80;
            4'd4:    b = data[15:8];
            4'd5:    b = data[7:0];
            4'd7:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ans_byte(input logic [IDX_W-1:0] idx,
                                            input logic [31:0] ttl,
                                            input logic [31:0] addr);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hC0;
            4'd1:    b = 8'h0C;
            4'd3:    b = 8'h01;
            4'd5:    b = 8'h01;
            4'd6:    b = ttl[31:24];
            4'd7:    b = ttl[23:16];
            4'd8:    b = ttl[15:8];
            4'd9:    b = ttl[7:0];
            4'd11:   b = 8'h04;
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            4'd15:   b = addr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dns_query_spoof_responder.sv -----
// Top level of the spoofed DNS query responder: configuration registers on the
// APB-style port, front part, command queue and back part.
// Depends on dqsr_pkg, dqsr_front, dqsr_cmd_fifo, dqsr_back.
//
//   channel   direction  handshake               payload
//   in        in         i_in_valid/o_in_ready   i_in_byte, i_in_last
//   out       out        o_out_valid/i_out_ready o_out_byte, o_out_last
//   config    in         psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// An input byte is taken while the command queue has room.
// The back part pops a command into a register, then sends its response bytes
// in order; it pops the next command only after the last of these is registered.
// Synchronous active-low reset; no clearing pass.
// A stalled output holds the back part; a full queue holds the input.
`default_nettype none

module dns_query_spoof_responder (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [7:0]                   i_in_byte,
    input  wire                          i_in_last,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [7:0]                   o_out_byte,
    output logic                         o_out_last,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [dqsr_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [31:0]            r_reply_address;
    logic [31:0]            r_answer_ttl;
    logic                   cfg_wr;
    logic                   in_accept;
    dqsr_pkg::t_cmd         push_cmd, head_cmd;
    dqsr_pkg::t_fifo_ctl    fifo_ctl;
    dqsr_pkg::t_fifo_stat   fifo_stat;
    logic                   push, pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == dqsr_pkg::REG_ANSWER_TTL) ? r_answer_ttl : r_reply_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_address <= dqsr_pkg::REPLY_ADDRESS_RESET;
            r_answer_ttl    <= dqsr_pkg::ANSWER_TTL_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                dqsr_pkg::REG_REPLY_ADDRESS: r_reply_address <= pwdata;
                dqsr_pkg::REG_ANSWER_TTL:    r_answer_ttl    <= pwdata;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !fifo_stat.full;
    assign in_accept  = i_in_valid && o_in_ready;
    assign fifo_ctl   = '{push: push, pop: pop};

    dqsr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    dqsr_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (fifo_ctl),
        .i_wr_cmd (push_cmd),
        .o_rd_cmd (head_cmd),
        .o_stat   (fifo_stat)
    );

    dqsr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_stat          (fifo_stat),
        .o_pop           (pop),
        .i_reply_address (r_reply_address),
        .i_answer_ttl    (r_answer_ttl),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last)
    );

endmodule

`default_nettype wire

// ----- rtl/dqsr_front.sv -----
// Front part: accepts query bytes, tracks the packet phase and turns each byte
// into at most one command for the back part. Depends on dqsr_pkg.
`default_nettype none

module dqsr_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire  [7:0]            i_in_byte,
    input  wire                   i_in_last,
    output logic                  o_push,
    output dqsr_pkg::t_cmd        o_cmd
);

    dqsr_pkg::t_phase            r_phase, n_phase;
    logic [dqsr_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [1:0]                  r_tail, n_tail;
    logic [7:0]                  r_id_hi, r_id_lo, r_qd_hi, r_qd_lo;
    logic                        eff_last;
    logic                        done;
    logic                        hdr_end;

    assign eff_last = i_in_last ||
                      (r_pos == dqsr_pkg::POS_W'(dqsr_pkg::MAX_PACKET - 1));
    assign hdr_end  = (r_pos == dqsr_pkg::POS_W'(dqsr_pkg::HDR_LEN - 1));

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_tail  = r_tail;
        done    = 1'b0;
        o_push  = 1'b0;
        o_cmd   = '{lead_hdr: 1'b0, data: {24'd0, i_in_byte}, fin: 1'b0, pad: 3'd0};
        if (i_accept) begin
            case (r_phase)
                dqsr_pkg::PH_DROP: begin
                    if (i_in_last) begin
                        n_phase = dqsr_pkg::PH_HEADER;
                        n_pos   = '0;
                        n_tail  = '0;
                    end
                end
                dqsr_pkg::PH_HEADER: begin
                    if (hdr_end) begin
                        o_push       = 1'b1;
                        o_cmd.lead_hdr = 1'b1;
                        o_cmd.data   = {r_id_hi, r_id_lo, r_qd_hi, r_qd_lo};
                        o_cmd.fin    = eff_last;
                        o_cmd.pad    = dqsr_pkg::PAD_NAME;
                        n_phase      = dqsr_pkg::PH_NAME;
                    end
                    done = eff_last;
                end
                dqsr_pkg::PH_NAME: begin
                    o_push    = 1'b1;
                    o_cmd.fin = eff_last;
                    if (i_in_byte == 8'h00) begin
                        n_phase   = dqsr_pkg::PH_TYPECLASS;
                        n_tail    = '0;
                        o_cmd.pad = dqsr_pkg::PAD_TYPECLS;
                    end else begin
                        o_cmd.pad = dqsr_pkg::PAD_NAME;
                    end
                    done = eff_last;
                end
                dqsr_pkg::PH_TYPECLASS: begin
                    o_push = 1'b1;
                    n_tail = r_tail + 2'd1;
                    if (r_tail == dqsr_pkg::TAIL_LAST) begin
                        o_cmd.fin = 1'b1;
                        o_cmd.pad = 3'd0;
                        done      = 1'b1;
                    end else if (eff_last) begin
                        o_cmd.fin = 1'b1;
                        o_cmd.pad = {1'b0, dqsr_pkg::TAIL_LAST - r_tail};
                        done      = 1'b1;
                    end
                end
                default: begin
                    n_phase = dqsr_pkg::PH_HEADER;
                end
            endcase
            if (r_phase != dqsr_pkg::PH_DROP) begin
                n_pos = r_pos + dqsr_pkg::POS_W'(1);
                if (done || eff_last) begin
                    n_tail  = '0;
                    n_pos   = '0;
                    n_phase = i_in_last ? dqsr_pkg::PH_HEADER : dqsr_pkg::PH_DROP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dqsr_pkg::PH_HEADER;
            r_pos   <= '0;
            r_tail  <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_tail  <= n_tail;
        end
    end

    // hold the header bytes that pass into the response
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == dqsr_pkg::PH_HEADER) begin
            case (r_pos[3:0])
                4'd0:    r_id_hi <= i_in_byte;
                4'd1:    r_id_lo <= i_in_byte;
                4'd4:    r_qd_hi <= i_in_byte;
                4'd5:    r_qd_lo <= i_in_byte;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dqsr_cmd_fifo.sv -----
// Short command queue between the front part and the back part.
// Depends on dqsr_pkg.
`default_nettype none

module dqsr_cmd_fifo (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  dqsr_pkg::t_fifo_ctl     i_ctl,
    input  dqsr_pkg::t_cmd          i_wr_cmd,
    output dqsr_pkg::t_cmd          o_rd_cmd,
    output dqsr_pkg::t_fifo_stat    o_stat
);

    dqsr_pkg::t_cmd                   r_mem [dqsr_pkg::FIFO_DEPTH];
    logic [dqsr_pkg::FIFO_PTR_W-1:0]  r_wr, r_rd;
    logic [dqsr_pkg::FIFO_CNT_W-1:0]  r_cnt, n_cnt;
    logic                             do_push, do_pop;

    assign o_stat.full  = (r_cnt == dqsr_pkg::FIFO_CNT_W'(dqsr_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_ctl.push && !o_stat.full;
    assign do_pop  = i_ctl.pop && !o_stat.empty;
    assign o_rd_cmd = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + dqsr_pkg::FIFO_CNT_W'(1);
            2'b01:   n_cnt = r_cnt - dqsr_pkg::FIFO_CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wr <= r_wr + dqsr_pkg::FIFO_PTR_W'(1);
            if (do_pop)  r_rd <= r_rd + dqsr_pkg::FIFO_PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_wr_cmd;
    end

endmodule

`default_nettype wire

// ----- rtl/dqsr_back.sv -----
// Back part: expands each command into response bytes (header, passed byte,
// zero padding, answer record) and drives the output register.
// Depends on dqsr_pkg.
`default_nettype none

module dqsr_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  dqsr_pkg::t_cmd          i_cmd,
    input  dqsr_pkg::t_fifo_stat    i_stat,
    output logic                    o_pop,
    input  wire  [31:0]             i_reply_address,
    input  wire  [31:0]             i_answer_ttl,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [7:0]              o_out_byte,
    output logic                    o_out_last
);

    dqsr_pkg::t_back_state        r_state, n_state;
    dqsr_pkg::t_cmd               r_cmd;
    logic [dqsr_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                         r_valid, n_valid;
    logic [7:0]                   r_byte, n_byte;
    logic                         r_last, n_last;
    logic                         adv;
    logic                         lead_end;

    assign adv      = !r_valid || i_out_ready;
    assign lead_end = !r_cmd.lead_hdr ||
                      (r_idx == dqsr_pkg::IDX_W'(dqsr_pkg::HDR_LEN - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (adv) begin
            n_valid = 1'b0;
            n_last  = 1'b0;
            case (r_state)
                dqsr_pkg::BK_IDLE: begin
                    if (!i_stat.empty) begin
                        o_pop   = 1'b1;
                        n_state = dqsr_pkg::BK_LEAD;
                        n_idx   = '0;
                    end
                end
                dqsr_pkg::BK_LEAD: begin
                    n_valid = 1'b1;
                    n_byte  = r_cmd.lead_hdr ? dqsr_pkg::hdr_byte(r_idx, r_cmd.data)
                                             : r_cmd.data[7:0];
                    n_idx   = r_idx + dqsr_pkg::IDX_W'(1);
                    if (lead_end) begin
                        n_idx = '0;
                        if (!r_cmd.fin)            n_state = dqsr_pkg::BK_IDLE;
                        else if (r_cmd.pad != '0)  n_state = dqsr_pkg::BK_PAD;
                        else                       n_state = dqsr_pkg::BK_ANS;
                    end
                end
                dqsr_pkg::BK_PAD: begin
                    n_valid = 1'b1;
                    n_byte  = 8'h00;
                    n_idx   = r_idx + dqsr_pkg::IDX_W'(1);
                    if (r_idx == dqsr_pkg::IDX_W'({1'b0, r_cmd.pad} - 4'd1)) begin
                        n_idx   = '0;
                        n_state = dqsr_pkg::BK_ANS;
                    end
                end
                dqsr_pkg::BK_ANS: begin
                    n_valid = 1'b1;
                    n_byte  = dqsr_pkg::ans_byte(r_idx, i_answer_ttl, i_reply_address);
                    n_idx   = r_idx + dqsr_pkg::IDX_W'(1);
                    if (r_idx == dqsr_pkg::IDX_W'(dqsr_pkg::ANS_LEN - 1)) begin
                        n_last  = 1'b1;
                        n_idx   = '0;
                        n_state = dqsr_pkg::BK_IDLE;
                    end
                end
                default: begin
                    n_state = dqsr_pkg::BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqsr_pkg::BK_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (o_pop) r_cmd <= i_cmd;
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_out_last  = r_last;

endmodule

`default_nettype wire
